// File: rtl/core/srsm_pkg.sv
// ----------------------------------------------------------------------------
// srsm_pkg - shared types and constants of the scanline run segmenter
// Widths, class and register codes, record structs, classify and pattern
// history update functions.
// ----------------------------------------------------------------------------
package srsm_pkg;

	localparam int LINE_MAX    = 4096;
	localparam int PATTERN_LEN = 5;
	localparam int HIST_DEPTH  = PATTERN_LEN - 1;
	localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
	localparam int HIST_CNT_W  = $clog2(PATTERN_LEN);
	localparam int IDX_W       = $clog2(LINE_MAX);
	localparam int LEN_W       = IDX_W + 1;
	localparam int PIX_W       = 8;
	localparam int CLS_W       = 2;
	localparam int PAT_W       = CLS_W * PATTERN_LEN;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = PAT_W;

	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = OUTQ_PTR_W + 1;

	localparam logic [PIX_W-1:0] LEVEL_DARK_RST   = 8'd0;
	localparam logic [PIX_W-1:0] LEVEL_MID_RST    = 8'd128;
	localparam logic [PIX_W-1:0] LEVEL_BRIGHT_RST = 8'd255;
	localparam logic [PAT_W-1:0] PATTERN_RST      = 10'd493;

	typedef enum logic [CLS_W-1:0] {
		CLS_NONE   = 2'd0,
		CLS_DARK   = 2'd1,
		CLS_MID    = 2'd2,
		CLS_BRIGHT = 2'd3
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_DARK   = 2'd0,
		REG_LEVEL_MID    = 2'd1,
		REG_LEVEL_BRIGHT = 2'd2,
		REG_PATTERN      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] level_dark;
		logic [PIX_W-1:0] level_mid;
		logic [PIX_W-1:0] level_bright;
		logic [PAT_W-1:0] pattern;
	} cfg_t;

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] mid;
		logic             last;
		logic             found;
	} rec_t;

	// Up to two records per pixel; r0 always first, r1 only with v1.
	typedef struct packed {
		logic v0;
		logic v1;
		rec_t r0;
		rec_t r1;
	} push_t;

	typedef struct packed {
		logic [HIST_DEPTH-1:0][CLS_W-1:0] h;
		logic [HIST_CNT_W-1:0]            cnt;
		logic                             found;
	} hist_t;

	// Highest class wins when levels coincide.
	function automatic logic [CLS_W-1:0] classify(logic [PIX_W-1:0] v,
			logic [CLS_W-1:0] keep, cfg_t c);
		logic [CLS_W-1:0] r;
		r = keep;
		if (v == c.level_dark)   r = CLS_DARK;
		if (v == c.level_mid)    r = CLS_MID;
		if (v == c.level_bright) r = CLS_BRIGHT;
		return r;
	endfunction

	// Compare history plus newest class against the pattern, then push it.
	function automatic hist_t record_class(hist_t hi, logic [CLS_W-1:0] cls,
			logic [PAT_W-1:0] pat);
		hist_t r;
		logic  match;
		logic  full;
		r     = hi;
		match = 1'b1;
		full  = (hi.cnt >= HIST_CNT_W'(HIST_DEPTH));
		for (int k = 0; k < HIST_DEPTH; k++) begin
			if (hi.h[k] != pat[CLS_W*k +: CLS_W]) match = 1'b0;
		end
		if (cls != pat[CLS_W*HIST_DEPTH +: CLS_W]) match = 1'b0;
		if (full && match) r.found = 1'b1;
		if (full) begin
			for (int k = 0; k < HIST_DEPTH - 1; k++) begin
				r.h[k] = hi.h[k+1];
			end
			r.h[HIST_DEPTH-1] = cls;
		end else begin
			r.h[hi.cnt[HIST_IDX_W-1:0]] = cls;
			r.cnt = hi.cnt + 1'b1;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/srsm_ifs.sv
// ----------------------------------------------------------------------------
// srsm channel interfaces
// Pixel input, run record output and register write channels.
// ----------------------------------------------------------------------------
interface srsm_pix_if;
	import srsm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             end_of_line;
	modport source (output valid, pixel_value, end_of_line, input ready);
	modport sink   (input valid, pixel_value, end_of_line, output ready);
endinterface

interface srsm_run_if;
	import srsm_pkg::*;
	logic             valid;
	logic             ready;
	logic [CLS_W-1:0] run_class;
	logic [LEN_W-1:0] run_length;
	logic [IDX_W-1:0] run_midpoint;
	logic             last_of_line;
	logic             pattern_found;
	modport source (output valid, run_class, run_length, run_midpoint, last_of_line,
		pattern_found, input ready);
	modport sink   (input valid, run_class, run_length, run_midpoint, last_of_line,
		pattern_found, output ready);
endinterface

interface srsm_cfg_if;
	import srsm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/srsm_cfg.sv
// ----------------------------------------------------------------------------
// srsm_cfg - level and pattern registers
// Always ready; takes every register write word.
// ----------------------------------------------------------------------------
module srsm_cfg (
	input  logic           clk,
	input  logic           arst_n,
	srsm_cfg_if.sink       cfg,
	output srsm_pkg::cfg_t regs
);
	import srsm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.level_dark   <= LEVEL_DARK_RST;
			regs_q.level_mid    <= LEVEL_MID_RST;
			regs_q.level_bright <= LEVEL_BRIGHT_RST;
			regs_q.pattern      <= PATTERN_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LEVEL_DARK:   regs_q.level_dark   <= cfg.data[PIX_W-1:0];
				REG_LEVEL_MID:    regs_q.level_mid    <= cfg.data[PIX_W-1:0];
				REG_LEVEL_BRIGHT: regs_q.level_bright <= cfg.data[PIX_W-1:0];
				REG_PATTERN:      regs_q.pattern      <= cfg.data[PAT_W-1:0];
				default:          ;
			endcase
		end
	end

endmodule

// File: rtl/core/srsm_seg.sv
// ----------------------------------------------------------------------------
// srsm_seg - run segmentation core
// Input register, run and pattern state; makes up to two records per pixel.
// ----------------------------------------------------------------------------
module srsm_seg (
	input  logic            clk,
	input  logic            arst_n,
	srsm_pix_if.sink        pix,
	input  srsm_pkg::cfg_t  regs,
	input  logic            room,
	output srsm_pkg::push_t push
);
	import srsm_pkg::*;

	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             eol_s1;

	logic [PIX_W-1:0] prev_q;
	logic [CLS_W-1:0] cls_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] idx_q;
	hist_t            hist_q;
	logic             started_q;

	logic             adv;
	logic             chg;
	logic [IDX_W-1:0] nxt;
	logic [CLS_W-1:0] cls_n;
	logic [LEN_W-1:0] len_n;
	logic [IDX_W-1:0] start_n;
	logic [IDX_W-1:0] idx_n;
	hist_t            hist1;
	hist_t            hist2;
	logic [IDX_W:0]   sum0;
	logic [IDX_W:0]   sum1;
	rec_t             rec_closed;
	rec_t             rec_final;

	assign adv       = valid_s1 && room;
	assign pix.ready = !valid_s1 || adv;
	assign chg       = started_q && (pix_s1 != prev_q);
	assign nxt       = (idx_q == IDX_W'(LINE_MAX - 1)) ? idx_q : idx_q + 1'b1;

	always_comb begin
		cls_n   = cls_q;
		len_n   = len_q;
		start_n = start_q;
		idx_n   = idx_q;
		hist1   = hist_q;
		if (!started_q) begin
			cls_n   = classify(pix_s1, CLS_NONE, regs);
			len_n   = LEN_W'(1);
			start_n = '0;
			idx_n   = '0;
		end else begin
			if (chg) begin
				hist1   = record_class(hist_q, cls_q, regs.pattern);
				cls_n   = classify(pix_s1, cls_q, regs);
				len_n   = LEN_W'(1);
				start_n = nxt;
			end else if (len_q < LEN_W'(LINE_MAX)) begin
				len_n = len_q + 1'b1;
			end
			idx_n = nxt;
		end
		hist2 = record_class(hist1, cls_n, regs.pattern);
	end

	assign sum0 = {1'b0, start_q} + {1'b0, idx_q};
	assign sum1 = {1'b0, start_n} + {1'b0, idx_n};

	always_comb begin
		rec_closed.cls   = cls_q;
		rec_closed.len   = len_q;
		rec_closed.mid   = sum0[IDX_W:1];
		rec_closed.last  = 1'b0;
		rec_closed.found = 1'b0;
		rec_final.cls    = cls_n;
		rec_final.len    = len_n;
		rec_final.mid    = sum1[IDX_W:1];
		rec_final.last   = 1'b1;
		rec_final.found  = hist2.found;
		push.v0 = adv && (chg || eol_s1);
		push.v1 = adv && chg && eol_s1;
		push.r0 = chg ? rec_closed : rec_final;
		push.r1 = rec_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pix_s1 <= pix.pixel_value;
			eol_s1 <= pix.end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			cls_q     <= '0;
			len_q     <= '0;
			start_q   <= '0;
			idx_q     <= '0;
			hist_q    <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			if (eol_s1) begin
				prev_q    <= '0;
				cls_q     <= '0;
				len_q     <= '0;
				start_q   <= '0;
				idx_q     <= '0;
				hist_q    <= '0;
				started_q <= 1'b0;
			end else begin
				prev_q    <= pix_s1;
				cls_q     <= cls_n;
				len_q     <= len_n;
				start_q   <= start_n;
				idx_q     <= idx_n;
				hist_q    <= hist1;
				started_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/srsm_outq.sv
// ----------------------------------------------------------------------------
// srsm_outq - run record queue
// Four-entry register queue; takes up to two records a cycle while room is high, gives one.
// ----------------------------------------------------------------------------
module srsm_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  srsm_pkg::push_t push,
	output logic            room,
	srsm_run_if.source      run
);
	import srsm_pkg::*;

	rec_t                  mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_q;
	logic [OUTQ_PTR_W-1:0] rd_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic [OUTQ_PTR_W-1:0] wr1;
	logic                  pop;
	rec_t                  head;

	assign wr1  = wr_q + 1'b1;
	assign pop  = run.valid && run.ready;
	assign room = (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
	assign head = mem_q[rd_q];

	assign run.valid         = (cnt_q != '0);
	assign run.run_class     = head.cls;
	assign run.run_length    = head.len;
	assign run.run_midpoint  = head.mid;
	assign run.last_of_line  = head.last;
	assign run.pattern_found = head.found;

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.r0;
		if (push.v1) mem_q[wr1]  <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OUTQ_PTR_W'(push.v0) + OUTQ_PTR_W'(push.v1);
			rd_q  <= rd_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + OUTQ_CNT_W'(push.v0) + OUTQ_CNT_W'(push.v1)
				- OUTQ_CNT_W'(pop);
		end
	end

endmodule

// File: rtl/core/scanline_run_segmenter_pattern_match.sv
// ----------------------------------------------------------------------------
// scanline_run_segmenter_pattern_match - scanline run segmenter top level
// Splits scanlines into runs of equal pixel value and searches run classes
// for a five-class pattern.
// ----------------------------------------------------------------------------
// Usage:
//   pix  - one pixel word per transfer (pixel_value, end_of_line); the word
//          that carries end_of_line closes the line.
//   run  - run record words: class, length, floor midpoint, last_of_line and,
//          on the last record only, pattern_found for the whole line.
//   cfg  - register writes (0 dark, 1 mid, 2 bright level, 3 pattern word);
//          always ready, issue only while no pixel is in flight.
//   Path: a taken pixel waits in the input register until the output queue
//   has room; its records are written into the queue as it leaves that
//   register, and run shows them from the queue head.
//   Throughput: one pixel per cycle while the output queue has room. A value
//   change on the end-of-line pixel gives two records, and the single output
//   port then sets the pace for that pixel.
//   Stall: the four-entry output queue holds records while run.ready is low;
//   once fewer than two entries are free, hold the word in the input
//   register, and pix.ready drops while that register is occupied and held.
//   Reset: levels return to 0/128/255, pattern to 493, all line state
//   cleared, input register and output queue empty.
// ----------------------------------------------------------------------------
module scanline_run_segmenter_pattern_match (
	input  logic       clk,
	input  logic       arst_n,
	srsm_pix_if.sink   pix,
	srsm_run_if.source run,
	srsm_cfg_if.sink   cfg
);
	import srsm_pkg::*;

	cfg_t  regs;
	push_t push;
	logic  room;

	// Hold levels and pattern word.
	srsm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Classify, close runs, advance pattern history.
	srsm_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.regs   (regs),
		.room   (room),
		.push   (push)
	);

	// Queue records towards the sink.
	srsm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.run    (run)
	);

endmodule

// File: rtl/core/srsm_chk.sv
// ----------------------------------------------------------------------------
// srsm_chk - port checker for the scanline run segmenter
// Watches the record and pixel channels; bound to the top level.
// ----------------------------------------------------------------------------
module srsm_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   pix_valid,
	input logic                   pix_ready,
	input logic                   run_valid,
	input logic                   run_ready,
	input logic [srsm_pkg::CLS_W-1:0] run_class,
	input logic [srsm_pkg::LEN_W-1:0] run_length,
	input logic [srsm_pkg::IDX_W-1:0] run_midpoint,
	input logic                   last_of_line,
	input logic                   pattern_found
);
	import srsm_pkg::*;

	// A found flag only ever rides on the closing record of a line.
	a_found_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> (!pattern_found || last_of_line))
		else $error("pattern_found set on a record that is not last");

	// No run is empty or longer than a line.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> (run_length != '0 && run_length <= LEN_W'(LINE_MAX)))
		else $error("run_length out of range");

	// A stalled record holds.
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid && $stable(run_class)
			&& $stable(run_length) && $stable(run_midpoint)
			&& $stable(last_of_line) && $stable(pattern_found))
		else $error("stalled record changed");

	// When reset is released, nothing comes out and no input is refused.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !run_valid && pix_ready)
		else $error("block not idle after reset");

	// A pixel refused at the input means the output side was stalled.
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |-> run_valid)
		else $error("input stalled without pending records");

endmodule

bind scanline_run_segmenter_pattern_match srsm_chk u_srsm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.run_valid     (run.valid),
	.run_ready     (run.ready),
	.run_class     (run.run_class),
	.run_length    (run.run_length),
	.run_midpoint  (run.run_midpoint),
	.last_of_line  (run.last_of_line),
	.pattern_found (run.pattern_found)
);

// File: sim/scanline_run_segmenter_pattern_match_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanline_run_segmenter_pattern_match_tb - run segmenter self-checking bench
// Streams scanlines into the block under random stalls on both channels and
// checks each run word against an in-bench model of the segmenter and its
// class-pattern search, across several register settings.
// ----------------------------------------------------------------------------
module scanline_run_segmenter_pattern_match_tb;
	import srsm_pkg::*;

	// Cycles without any accepted word before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let the block settle after the last expected run word.
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;

	srsm_pix_if pix ();
	srsm_run_if run ();
	srsm_cfg_if cfg ();

	scanline_run_segmenter_pattern_match uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.run    (run),
		.cfg    (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One closed run as the block should report it.
	typedef struct {
		cls_t             cls;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] mid;
		logic             last;
		logic             found;
	} run_word_t;

	run_word_t expected_runs[$];
	run_word_t got_word;
	int        fail_count = 0;
	int        pixels_sent = 0;
	// While set, neither side inserts gaps.
	bit        steady = 1'b0;

	// Register shadow, kept in step with every accepted register write.
	logic [PIX_W-1:0] lvl_dark   = LEVEL_DARK_RST;
	logic [PIX_W-1:0] lvl_mid    = LEVEL_MID_RST;
	logic [PIX_W-1:0] lvl_bright = LEVEL_BRIGHT_RST;
	logic [PAT_W-1:0] pattern_sought = PATTERN_RST;

	// Line state of the segmenter model.
	logic [PIX_W-1:0] prev_v = '0;
	cls_t             cur_cls = CLS_NONE;
	int               cur_len = 0;
	int               run_start = 0;
	int               pix_idx = 0;
	cls_t             hist[HIST_DEPTH] = '{default: CLS_NONE};
	int               hist_cnt = 0;
	logic             seen_pattern = 1'b0;
	bit               line_open = 1'b0;

	// ------------------------------------------------------------------
	// Segmenter model
	// ------------------------------------------------------------------

	// Highest class wins when several levels hold the same value.
	function automatic cls_t level_class(logic [PIX_W-1:0] v, cls_t keep);
		cls_t c;
		c = keep;
		if (v == lvl_dark)   c = CLS_DARK;
		if (v == lvl_mid)    c = CLS_MID;
		if (v == lvl_bright) c = CLS_BRIGHT;
		return c;
	endfunction

	// Compare the last four run classes plus this one with the pattern,
	// then shift this one into the history.
	task automatic note_run_class(cls_t c);
		bit hit;
		hit = 1'b1;
		if (hist_cnt >= HIST_DEPTH) begin
			for (int k = 0; k < HIST_DEPTH; k++) begin
				if (hist[k] != pattern_sought[CLS_W*k +: CLS_W]) hit = 1'b0;
			end
			if (c != pattern_sought[CLS_W*HIST_DEPTH +: CLS_W]) hit = 1'b0;
			if (hit) seen_pattern = 1'b1;
			for (int k = 0; k < HIST_DEPTH - 1; k++) hist[k] = hist[k+1];
			hist[HIST_DEPTH-1] = c;
		end else begin
			hist[hist_cnt] = c;
			hist_cnt++;
		end
	endtask

	task automatic queue_run_word(int last_idx, logic last, logic found);
		expected_runs.push_back('{cur_cls, LEN_W'(cur_len),
			IDX_W'((run_start + last_idx) >> 1), last, found});
	endtask

	task automatic segment_pixel(logic [PIX_W-1:0] v, logic eol);
		int nxt;
		if (!line_open) begin
			cur_cls   = level_class(v, CLS_NONE);
			cur_len   = 1;
			run_start = 0;
			pix_idx   = 0;
		end else begin
			// Index saturates on overlong lines; runs keep being cut.
			nxt = (pix_idx + 1 > LINE_MAX - 1) ? LINE_MAX - 1 : pix_idx + 1;
			if (v != prev_v) begin
				note_run_class(cur_cls);
				queue_run_word(pix_idx, 1'b0, 1'b0);
				cur_cls   = level_class(v, cur_cls);
				cur_len   = 1;
				run_start = nxt;
			end else if (cur_len < LINE_MAX) begin
				cur_len++;
			end
			pix_idx = nxt;
		end
		prev_v = v;
		if (eol) begin
			note_run_class(cur_cls);
			queue_run_word(pix_idx, 1'b1, seen_pattern);
			// Drop all line state; the next pixel opens a fresh line.
			prev_v       = '0;
			cur_cls      = CLS_NONE;
			cur_len      = 0;
			run_start    = 0;
			pix_idx      = 0;
			hist         = '{default: CLS_NONE};
			hist_cnt     = 0;
			seen_pattern = 1'b0;
			line_open    = 1'b0;
		end else begin
			line_open = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 28);
	endfunction

	// Offer one pixel word and hold it until taken. Valid is left high on
	// return so back-to-back words need no dip; pix_quiet drops it.
	task automatic send_pixel(logic [PIX_W-1:0] v, logic eol);
		while (take_break()) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel_value <= v;
		pix.end_of_line <= eol;
		do @(posedge clk); while (!pix.ready);
		segment_pixel(v, eol);
		pixels_sent++;
	endtask

	task automatic pix_quiet();
		pix.valid <= 1'b0;
	endtask

	// Hold the sender until every expected run word is back, then give the
	// block time to finish any pixel that closed no run.
	task automatic settle_block();
		pix_quiet();
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_LEVEL_DARK:   lvl_dark = d[PIX_W-1:0];
			REG_LEVEL_MID:    lvl_mid = d[PIX_W-1:0];
			REG_LEVEL_BRIGHT: lvl_bright = d[PIX_W-1:0];
			REG_PATTERN:      pattern_sought = d;
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_block(logic [CFG_DATA_W-1:0] d, logic [CFG_DATA_W-1:0] m,
			logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] p);
		write_reg(REG_LEVEL_DARK, d);
		write_reg(REG_LEVEL_MID, m);
		write_reg(REG_LEVEL_BRIGHT, b);
		write_reg(REG_PATTERN, p);
	endtask

	task automatic send_run(logic [PIX_W-1:0] v, int n, bit closes);
		for (int i = 0; i < n; i++) send_pixel(v, closes && (i == n - 1));
	endtask

	// ------------------------------------------------------------------
	// Run word checker and receiver stalls
	// ------------------------------------------------------------------

	task automatic log_fault(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && run.valid && run.ready) begin
			if (expected_runs.size() == 0) begin
				log_fault($sformatf("unexpected run word cls=%0d len=%0d mid=%0d last=%0b found=%0b",
					run.run_class, run.run_length, run.run_midpoint,
					run.last_of_line, run.pattern_found));
			end else begin
				got_word = expected_runs.pop_front();
				if (run.run_class !== got_word.cls || run.run_length !== got_word.len ||
						run.run_midpoint !== got_word.mid ||
						run.last_of_line !== got_word.last ||
						run.pattern_found !== got_word.found) begin
					log_fault($sformatf({"run word mismatch exp cls=%0d len=%0d mid=%0d ",
						"last=%0b found=%0b got cls=%0d len=%0d mid=%0d last=%0b found=%0b"},
						got_word.cls, got_word.len, got_word.mid, got_word.last,
						got_word.found, run.run_class, run.run_length, run.run_midpoint,
						run.last_of_line, run.pattern_found));
				end
			end
		end
		run.ready <= !take_break();
	end

	// Watchdog: any accepted word on any channel counts as progress.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (run.valid && run.ready) ||
					(cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly level values, so classes and patterns actually occur.
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(4))
			0: return lvl_dark;
			1: return lvl_mid;
			2: return lvl_bright;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	// Value that yields class c as the next run. Where the wanted class is
	// the one already held (or none), use a value matching no level.
	function automatic logic [PIX_W-1:0] value_for_class(cls_t c, cls_t held, bit open_line);
		logic [PIX_W-1:0] v;
		case (c)
			CLS_DARK:   v = lvl_dark;
			CLS_MID:    v = lvl_mid;
			CLS_BRIGHT: v = lvl_bright;
			default:    v = '0;
		endcase
		if (c == held || c == CLS_NONE || (open_line && v == prev_v)) begin
			do v = PIX_W'($urandom_range(255));
			while (v == lvl_dark || v == lvl_mid || v == lvl_bright ||
				(open_line && v == prev_v));
		end
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] level_word(logic [PIX_W-1:0] lv);
		// Upper bits are junk the block must drop.
		return {2'($urandom_range(3)), lv};
	endfunction

	// Three distinct random levels and a random pattern.
	task automatic program_random();
		logic [PIX_W-1:0] d, m, b;
		d = PIX_W'($urandom_range(255));
		do m = PIX_W'($urandom_range(255)); while (m == d);
		do b = PIX_W'($urandom_range(255)); while (b == d || b == m);
		program_block(level_word(d), level_word(m), level_word(b),
			PAT_W'($urandom_range(1023)));
	endtask

	task automatic send_level_line();
		int runs;
		runs = $urandom_range(1, 10);
		for (int r = 0; r < runs; r++) begin
			send_run(pick_pixel(),
				($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4),
				r == runs - 1);
		end
	endtask

	task automatic send_noise_line();
		int len;
		logic [PIX_W-1:0] v;
		len = $urandom_range(1, 30);
		v = PIX_W'($urandom_range(255));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) != 0) v = PIX_W'($urandom_range(255));
			send_pixel(v, i == len - 1);
		end
	endtask

	// Random runs around five runs whose classes spell the pattern.
	task automatic send_planted_line();
		int pre, post;
		cls_t code;
		pre  = $urandom_range(0, 3);
		post = $urandom_range(0, 2);
		for (int r = 0; r < pre; r++) send_run(pick_pixel(), $urandom_range(1, 3), 1'b0);
		for (int k = 0; k < PATTERN_LEN; k++) begin
			code = cls_t'(pattern_sought[CLS_W*k +: CLS_W]);
			send_run(value_for_class(code, line_open ? cur_cls : CLS_NONE, line_open),
				$urandom_range(1, 3), post == 0 && k == PATTERN_LEN - 1);
		end
		for (int r = 0; r < post; r++)
			send_run(pick_pixel(), $urandom_range(1, 3), r == post - 1);
	endtask

	task automatic random_phase(int n_items);
		int goal, pick;
		goal = pixels_sent + n_items;
		while (pixels_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 50)      send_level_line();
			else if (pick < 80) send_planted_line();
			else                send_noise_line();
			// Now and then hold off until the block has drained.
			if ($urandom_range(39) == 0) settle_block();
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset levels 0/128/255, pattern dark-bright-mid-bright-dark.
	task automatic test_default_levels();
		// Pattern hit, and a value change on the end-of-line pixel.
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b1);
		// Unclassified start, a kept class, and a line end with no change.
		send_pixel(8'd7, 1'b0);
		send_pixel(8'd7, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd9, 1'b0);
		send_pixel(8'd9, 1'b1);
		// One-pixel line.
		send_pixel(8'd200, 1'b1);
	endtask

	// Coinciding levels: the brighter class must win.
	task automatic test_level_overlap();
		settle_block();
		program_block(10'd77, 10'd77, 10'd77, PATTERN_RST);
		send_pixel(8'd77, 1'b0);
		send_pixel(8'd76, 1'b1);
		settle_block();
		program_block(10'd9, 10'd9, 10'd10, PATTERN_RST);
		send_pixel(8'd9, 1'b0);
		send_pixel(8'd10, 1'b0);
		send_pixel(8'd9, 1'b1);
	endtask

	// Register extremes, junk in the upper data bits, all-none and
	// all-bright patterns.
	task automatic test_register_extremes();
		settle_block();
		program_block(10'h3FF, 10'h300, 10'd254, 10'd0);
		for (int i = 1; i <= 5; i++) send_pixel(PIX_W'(i), i == 5);
		settle_block();
		write_reg(REG_PATTERN, 10'h3FF);
		for (int i = 0; i < 5; i++) send_pixel(PIX_W'(254 - i), i == 4);
	endtask

	// Line past LINE_MAX pixels: length and index both saturate.
	task automatic test_overlong_line();
		send_run(8'd33, LINE_MAX + 2, 1'b0);
		send_pixel(8'd34, 1'b0);
		send_pixel(8'd35, 1'b0);
		send_pixel(8'd36, 1'b0);
		send_pixel(8'd36, 1'b1);
	endtask

	task automatic test_random_lines();
		settle_block();
		program_random();
		random_phase(300);
		// Long stretch with both sides always willing.
		settle_block();
		program_random();
		steady = 1'b1;
		random_phase(300);
		steady = 1'b0;
		// Levels at the range ends.
		settle_block();
		program_block(10'd255, 10'd0, 10'd1, PAT_W'($urandom_range(1023)));
		random_phase(300);
		settle_block();
		program_random();
		random_phase(300);
	endtask

	initial begin
		arst_n          <= 1'b0;
		pix.valid       <= 1'b0;
		pix.pixel_value <= '0;
		pix.end_of_line <= 1'b0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_LEVEL_DARK;
		cfg.data        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_levels();
		test_level_overlap();
		test_register_extremes();
		test_overlong_line();
		test_random_lines();

		settle_block();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
